// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock, reset disabled
`define CHK_IMPL(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("check failed");
// Next-cycle implication
`define CHK_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("check failed");
`endif

// ===== hw/rtl/bfd_pkg.sv =====
// Shared types and constants for the best-fit disk request check
`timescale 1ns / 1ps
package bfd_pkg;
  localparam int LOCATIONS_DEF = 16;
  localparam int REQUESTS_DEF = 32;
  localparam int MEDIA_DEF = 8;
  localparam int MW = $clog2(MEDIA_DEF);
  localparam int AW = 62;
  localparam int FW = 64;

  localparam logic [1:0] OP_LOC = 2'd0;
  localparam logic [1:0] OP_REQ = 2'd1;
  localparam logic [1:0] OP_EMPTY = 2'd2;
  localparam logic [1:0] OP_EVAL = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [MW-1:0] medium_req;
    logic use_default_medium;
    logic [AW-1:0] amount;
    logic [AW-1:0] usage;
  } bfd_in_t;

  typedef struct packed {
    logic feasible;
    logic overflow;
  } bfd_out_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // take an input item
    logic clr;        // clear all stored state
    logic def_start;  // begin default-medium scan
    logic def_step;
    logic pick_start; // begin largest-request scan
    logic pick_step;
    logic fit_start;  // begin best-location scan
    logic fit_step;
    logic apply;      // subtract from best location
  } bfd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic overflowed;
    logic empty_seen;
    logic def_found;
    logic scan_last;   // current scan index is last
    logic fit_found;
    logic reqs_left;   // unserved requests remain
  } bfd_sts_t;
endpackage

// ===== hw/rtl/bfd_datapath.sv =====
// Datapath: location and request stores, scan registers and free-space update
`timescale 1ns / 1ps
module bfd_datapath import bfd_pkg::*; #(
  parameter int LOCATIONS = LOCATIONS_DEF,
  parameter int REQUESTS = REQUESTS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic [MW-1:0] default_medium,
  input  bfd_in_t in_beat,
  input  bfd_cmd_t cmd,
  output bfd_sts_t sts
);
  localparam int LI = (LOCATIONS > 1) ? $clog2(LOCATIONS) : 1;
  localparam int RI = (REQUESTS > 1) ? $clog2(REQUESTS) : 1;
  localparam int LC = $clog2(LOCATIONS + 1);
  localparam int RC = $clog2(REQUESTS + 1);
  localparam int SW = (LC > RC) ? LC : RC;

  logic [MW-1:0] loc_med [LOCATIONS];
  logic [FW-1:0] loc_free [LOCATIONS];
  logic [MW-1:0] req_med [REQUESTS];
  logic [AW-1:0] req_size [REQUESTS];
  logic [REQUESTS-1:0] served;
  logic [LC-1:0] loc_count;
  logic [RC-1:0] req_count;
  logic empty_seen, overflowed;

  logic [SW-1:0] idx;
  logic def_found;
  logic have;
  logic [RI-1:0] pick;
  logic [AW-1:0] pick_size;
  logic [MW-1:0] pick_med;
  logic fit;
  logic [LI-1:0] best;
  logic [FW-1:0] best_free;
  logic [MW-1:0] rd_lmed;
  logic [FW-1:0] rd_lfree;
  logic [AW-1:0] rd_rsize;
  logic served_i;
  logic [FW-1:0] need;

  assign rd_lmed = loc_med[idx[LI-1:0]];
  assign rd_lfree = loc_free[idx[LI-1:0]];
  assign rd_rsize = req_size[idx[RI-1:0]];
  assign served_i = served[idx[RI-1:0]];
  assign need = {2'b00, pick_size};

  always_ff @(posedge clk) begin
    if (cmd.load && in_beat.op == OP_LOC && loc_count < LC'(LOCATIONS)) begin
      loc_med[loc_count[LI-1:0]] <= in_beat.medium_req;
      loc_free[loc_count[LI-1:0]] <= {2'b00, in_beat.amount} - {2'b00, in_beat.usage};
    end else if (cmd.apply) begin
      loc_free[best] <= best_free - need;
    end
    if (cmd.load && in_beat.op == OP_REQ && req_count < RC'(REQUESTS)) begin
      req_med[req_count[RI-1:0]] <=
        in_beat.use_default_medium ? default_medium : in_beat.medium_req;
      req_size[req_count[RI-1:0]] <= in_beat.amount;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clr) begin
      loc_count <= '0;
      req_count <= '0;
      empty_seen <= 1'b0;
      overflowed <= 1'b0;
      served <= '0;
    end else begin
      if (cmd.load) begin
        case (in_beat.op)
          OP_LOC: begin
            if (loc_count < LC'(LOCATIONS)) loc_count <= loc_count + 1'b1;
            else overflowed <= 1'b1;
          end
          OP_REQ: begin
            if (req_count < RC'(REQUESTS)) req_count <= req_count + 1'b1;
            else overflowed <= 1'b1;
          end
          OP_EMPTY: empty_seen <= 1'b1;
          default: ;
        endcase
      end
      if (cmd.fit_start) served[pick] <= 1'b1;
    end
  end

  // scan registers
  always_ff @(posedge clk) begin
    if (cmd.def_start || cmd.pick_start || cmd.fit_start) begin
      idx <= '0;
      def_found <= 1'b0;
      have <= 1'b0;
      fit <= 1'b0;
      if (cmd.fit_start) pick_med <= req_med[pick];
    end else begin
      if (cmd.def_step || cmd.pick_step || cmd.fit_step) idx <= idx + 1'b1;
      if (cmd.def_step && SW'(idx) < SW'(loc_count) && rd_lmed == default_medium)
        def_found <= 1'b1;
      if (cmd.pick_step && SW'(idx) < SW'(req_count) && !served_i &&
          (!have || rd_rsize > pick_size)) begin
        have <= 1'b1;
        pick <= idx[RI-1:0];
        pick_size <= rd_rsize;
      end
      if (cmd.fit_step && SW'(idx) < SW'(loc_count) && rd_lmed == pick_med &&
          $signed(rd_lfree) >= $signed(need) &&
          (!fit || !($signed(rd_lfree) >= $signed(best_free)))) begin
        fit <= 1'b1;
        best <= idx[LI-1:0];
        best_free <= rd_lfree;
      end
    end
  end

  always_comb begin
    sts.overflowed = overflowed;
    sts.empty_seen = empty_seen;
    sts.def_found = def_found;
    sts.fit_found = fit;
    sts.reqs_left = (served != {REQUESTS{1'b1}}) &&
                    ($countones(served) < req_count);
    if (cmd.pick_step) sts.scan_last = (idx == SW'(REQUESTS - 1));
    else sts.scan_last = (idx == SW'(LOCATIONS - 1));
  end
endmodule

// ===== hw/rtl/bfd_ctrl.sv =====
// Controller: sequences load, scans and result for the check
`timescale 1ns / 1ps
module bfd_ctrl import bfd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [1:0] op,
  input  bfd_sts_t sts,
  output bfd_cmd_t cmd,
  output logic busy,
  output logic done,
  output bfd_out_t result
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DEF = 4'd1;
  localparam logic [3:0] S_DEFCHK = 4'd2;
  localparam logic [3:0] S_NEXT = 4'd3;
  localparam logic [3:0] S_PICK = 4'd4;
  localparam logic [3:0] S_FIT = 4'd5;
  localparam logic [3:0] S_APPLY = 4'd6;
  localparam logic [3:0] S_DONE = 4'd7;
  localparam logic [3:0] S_FITGO = 4'd8;

  logic [3:0] state, state_next;
  logic ok, ok_next;
  logic res_ovf, res_ovf_next;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ok <= 1'b0;
      res_ovf <= 1'b0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      ok <= ok_next;
      res_ovf <= res_ovf_next;
      done <= (state == S_DONE);
    end
  end
  always_ff @(posedge clk) begin
    if (state == S_DONE) result <= '{feasible: ok && !res_ovf, overflow: res_ovf};
  end

  always_comb begin
    state_next = state;
    ok_next = ok;
    res_ovf_next = res_ovf;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (op == OP_EVAL) begin
            res_ovf_next = sts.overflowed;
            ok_next = 1'b1;
            if (sts.overflowed) state_next = S_DONE;
            else begin
              cmd.def_start = 1'b1;
              state_next = sts.empty_seen ? S_DEF : S_NEXT;
            end
          end
        end
      end
      S_DEF: begin
        cmd.def_step = 1'b1;
        if (sts.scan_last) state_next = S_DEFCHK;
      end
      S_DEFCHK: begin
        if (!sts.def_found) begin
          ok_next = 1'b0;
          state_next = S_DONE;
        end else state_next = S_NEXT;
      end
      S_NEXT: begin
        if (sts.reqs_left) begin
          cmd.pick_start = 1'b1;
          state_next = S_PICK;
        end else state_next = S_DONE;
      end
      S_PICK: begin
        cmd.pick_step = 1'b1;
        if (sts.scan_last) begin
          state_next = S_FITGO;
        end
      end
      S_FITGO: begin
        cmd.fit_start = 1'b1;
        state_next = S_FIT;
      end
      S_FIT: begin
        cmd.fit_step = 1'b1;
        if (sts.scan_last) state_next = S_APPLY;
      end
      S_APPLY: begin
        if (!sts.fit_found) begin
          ok_next = 1'b0;
          state_next = S_DONE;
        end else begin
          cmd.apply = 1'b1;
          state_next = S_NEXT;
        end
      end
      S_DONE: begin
        cmd.clr = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

// ===== hw/rtl/best_fit_disk_request_check_unit.sv =====
// Top level of the best-fit disk request check
`timescale 1ns / 1ps
// Load beats (add location, add request, mark empty) may follow back to back.
// An evaluate beat holds busy while the controller walks the stores with
// one shared scan index: unless a store overflowed, a default-medium scan over
// the locations when an empty request was marked, then per request a scan for the
// largest unserved request and a scan for the best-fitting location, then the result. The result
// appears for one cycle with done high; the receiver cannot stall it. All
// stores clear after evaluate.
module best_fit_disk_request_check_unit import bfd_pkg::*; #(
  parameter int LOCATIONS = LOCATIONS_DEF,
  parameter int REQUESTS = REQUESTS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  bfd_in_t in_item,
  output logic done,
  output bfd_out_t result,
  input  logic cfg_we,
  input  logic [MW-1:0] cfg_wdata
);
  logic [MW-1:0] default_medium;
  bfd_cmd_t cmd;
  bfd_sts_t sts;

  always_ff @(posedge clk) begin
    if (rst) default_medium <= '0;
    else if (cfg_we) default_medium <= cfg_wdata;
  end

  bfd_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .op(in_item.op), .sts(sts),
    .cmd(cmd), .busy(busy), .done(done), .result(result)
  );

  bfd_datapath #(.LOCATIONS(LOCATIONS), .REQUESTS(REQUESTS)) u_dp (
    .clk(clk), .rst(rst), .default_medium(default_medium), .in_beat(in_item),
    .cmd(cmd), .sts(sts)
  );
endmodule

// ===== hw/rtl/bfd_checker.sv =====
// Port-level checker for the best-fit disk request check
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bfd_checker import bfd_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input bfd_in_t in_item,
  input logic done,
  input bfd_out_t result
);
  `CHK_IMPL(a_ovf_infeasible, clk, rst, done && result.overflow, !result.feasible)
  `CHK_NEXT(a_eval_busy, clk, rst, start && !busy && in_item.op == OP_EVAL, busy)
  `CHK_NEXT(a_load_idle, clk, rst, start && !busy && in_item.op != OP_EVAL, !busy && !done)
  `CHK_NEXT(a_done_pulse, clk, rst, done, !done)
endmodule

bind best_fit_disk_request_check_unit bfd_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .in_item(in_item),
  .done(done), .result(result)
);

// ===== tb/best_fit_disk_request_check_unit_tb.sv =====
// Testbench for the best-fit disk request check: directed table, then random load/evaluate runs
`timescale 1ns / 1ps
module best_fit_disk_request_check_unit_tb;
  import bfd_pkg::*;

  localparam int NLOC = LOCATIONS_DEF;
  localparam int NREQ = REQUESTS_DEF;
  localparam int RANDOM_BEATS = 1850;
  localparam longint CYCLE_LIMIT = 64'd2000000;

  typedef struct {
    bfd_in_t item;
    bit      known;
    bit      feasible;
    bit      overflow;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  bfd_in_t in_item = '0;
  logic done;
  bfd_out_t result;
  logic cfg_we = 1'b0;
  logic [MW-1:0] cfg_wdata = '0;

  logic [MW-1:0] dflt_medium;
  logic [MW-1:0] loc_medium [NLOC];
  logic [FW-1:0] loc_free [NLOC];
  int loc_cnt;
  logic [MW-1:0] req_medium [NREQ];
  logic [AW-1:0] req_size [NREQ];
  int req_cnt;
  bit empty_flag;
  bit over_flag;

  bfd_out_t verdict_q [$];
  int errors = 0;
  longint cycles = 0;
  row_t rows [$];

  best_fit_disk_request_check_unit uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_item(in_item),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("best_fit_disk_request_check_unit_tb failed");
      $finish;
    end
  end

  task automatic report(input string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (verdict_q.size() == 0) begin
        report("result with nothing pending");
      end else begin
        bfd_out_t want;
        want = verdict_q.pop_front();
        if (result.feasible !== want.feasible)
          report($sformatf("feasible %b want %b", result.feasible, want.feasible));
        if (result.overflow !== want.overflow)
          report($sformatf("overflow %b want %b", result.overflow, want.overflow));
      end
    end
  end

  function automatic void clear_stores();
    loc_cnt = 0;
    req_cnt = 0;
    empty_flag = 0;
    over_flag = 0;
  endfunction

  function automatic bit placement_fits();
    bit taken [NREQ];
    int pick, best;
    bit found;
    logic [FW-1:0] need;
    if (empty_flag) begin
      found = 0;
      for (int i = 0; i < loc_cnt; i++)
        if (loc_medium[i] == dflt_medium) found = 1;
      if (!found) return 0;
    end
    for (int i = 0; i < NREQ; i++) taken[i] = 0;
    for (int n = 0; n < req_cnt; n++) begin
      pick = -1;
      for (int i = 0; i < req_cnt; i++)
        if (!taken[i] && (pick < 0 || req_size[i] > req_size[pick])) pick = i;
      taken[pick] = 1;
      need = {2'b00, req_size[pick]};
      best = -1;
      for (int i = 0; i < loc_cnt; i++) begin
        if (loc_medium[i] != req_medium[pick]) continue;
        if ($signed(loc_free[i]) < $signed(need)) continue;
        if (best < 0 || $signed(loc_free[i]) < $signed(loc_free[best])) best = i;
      end
      if (best < 0) return 0;
      loc_free[best] = loc_free[best] - need;
    end
    return 1;
  endfunction

  function automatic bfd_out_t predict_beat(input bfd_in_t it);
    bfd_out_t r;
    r = '0;
    case (it.op)
      OP_LOC: begin
        if (loc_cnt < NLOC) begin
          loc_medium[loc_cnt] = it.medium_req;
          loc_free[loc_cnt] = {2'b00, it.amount} - {2'b00, it.usage};
          loc_cnt++;
        end else over_flag = 1;
      end
      OP_REQ: begin
        if (req_cnt < NREQ) begin
          req_medium[req_cnt] = it.use_default_medium ? dflt_medium : it.medium_req;
          req_size[req_cnt] = it.amount;
          req_cnt++;
        end else over_flag = 1;
      end
      OP_EMPTY: empty_flag = 1;
      default: begin
        if (over_flag) r.overflow = 1;
        else r.feasible = placement_fits();
        clear_stores();
      end
    endcase
    return r;
  endfunction

  task automatic send_beat(input bfd_in_t it, input bit known, input bit f, input bit o);
    bfd_out_t p;
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    p = predict_beat(it);
    if (it.op == OP_EVAL) begin
      if (known && (p.feasible != f || p.overflow != o))
        report("predictor disagrees with directed row");
      verdict_q = {verdict_q, p};
    end
    @(negedge clk);
  endtask

  task automatic go_idle(input int n);
    start <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic drain_and_config(input logic [MW-1:0] val);
    start <= 1'b0;
    while (verdict_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    while (busy) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    dflt_medium = val;
  endtask

  function automatic bfd_in_t mk(input logic [1:0] op, input logic [MW-1:0] m,
                                 input bit ud, input logic [AW-1:0] a,
                                 input logic [AW-1:0] u);
    bfd_in_t t;
    t.op = op; t.medium_req = m; t.use_default_medium = ud; t.amount = a; t.usage = u;
    return t;
  endfunction

  function automatic logic [AW-1:0] rnd_amt();
    logic [AW-1:0] v;
    case ($urandom_range(0, 5))
      0: v = '0;
      1: v = '1;
      2: v = AW'($urandom_range(0, 20));
      3: v = AW'({$urandom, $urandom});
      default: v = AW'($urandom_range(0, 1000));
    endcase
    return v;
  endfunction

  task automatic add_row(input bfd_in_t it, input bit k, input bit f, input bit o);
    row_t r;
    r.item = it; r.known = k; r.feasible = f; r.overflow = o;
    rows = {rows, r};
  endtask

  initial begin
    bfd_in_t it;
    int sent, burst, n_loc, n_req;
    logic [AW-1:0] mx;
    dflt_medium = '0;
    clear_stores();
    mx = '1;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    add_row(mk(OP_EVAL, 0, 0, 0, 0), 1, 1, 0);
    add_row(mk(OP_LOC, 7, 0, mx, 0), 0, 0, 0);
    add_row(mk(OP_REQ, 7, 0, mx, 0), 0, 0, 0);
    add_row(mk(OP_EVAL, 0, 0, 0, 0), 1, 1, 0);
    add_row(mk(OP_LOC, 2, 0, 5, 6), 0, 0, 0);
    add_row(mk(OP_REQ, 2, 0, 0, 0), 0, 0, 0);
    add_row(mk(OP_EVAL, 0, 0, 0, 0), 1, 0, 0);
    add_row(mk(OP_REQ, 3, 0, 0, 0), 0, 0, 0);
    add_row(mk(OP_EVAL, 0, 0, 0, 0), 1, 0, 0);
    add_row(mk(OP_EMPTY, 0, 0, 0, 0), 0, 0, 0);
    add_row(mk(OP_EVAL, 0, 0, 0, 0), 1, 0, 0);
    add_row(mk(OP_LOC, 0, 0, 10, 0), 0, 0, 0);
    add_row(mk(OP_LOC, 0, 0, 6, 0), 0, 0, 0);
    add_row(mk(OP_REQ, 5, 1, 6, mx), 0, 0, 0);
    add_row(mk(OP_REQ, 0, 0, 5, 0), 0, 0, 0);
    add_row(mk(OP_REQ, 0, 0, 5, 0), 0, 0, 0);
    add_row(mk(OP_EMPTY, 0, 0, 0, 0), 0, 0, 0);
    add_row(mk(OP_EVAL, 0, 0, 0, 0), 0, 0, 0);
    for (int i = 0; i < NLOC + 1; i++) add_row(mk(OP_LOC, 1, 0, 9, 0), 0, 0, 0);
    add_row(mk(OP_EVAL, 0, 0, 0, 0), 1, 0, 1);
    foreach (rows[i]) send_beat(rows[i].item, rows[i].known, rows[i].feasible,
                                rows[i].overflow);
    for (int i = 0; i < NREQ + 1; i++) send_beat(mk(OP_REQ, 1, 0, 0, 0), 0, 0, 0);
    send_beat(mk(OP_EVAL, 0, 0, 0, 0), 1, 0, 1);

    sent = 0;
    while (sent < RANDOM_BEATS) begin
      if ((sent / 300) % 2 == 0 || sent < 300)
        drain_and_config((sent / 300 == 1) ? 3'd7 : 3'($urandom_range(0, 7)));
      else
        drain_and_config(3'($urandom_range(0, 7)));
      for (int s = 0; s < 300 && sent < RANDOM_BEATS; ) begin
        n_loc = ($urandom_range(0, 9) == 0) ? $urandom_range(0, NLOC + 2)
                                            : $urandom_range(0, 6);
        n_req = ($urandom_range(0, 9) == 0) ? $urandom_range(0, NREQ + 2)
                                            : $urandom_range(0, 6);
        burst = 0;
        for (int k = 0; k < n_loc + n_req + 1; k++) begin
          if ($urandom_range(0, 9) == 0)
            it = mk(OP_EMPTY, MW'($urandom), 1'($urandom), rnd_amt(), rnd_amt());
          else if (k < n_loc)
            it = mk(OP_LOC, MW'($urandom_range(0, 3)), 1'($urandom), rnd_amt(),
                    rnd_amt());
          else if (k < n_loc + n_req)
            it = mk(OP_REQ, MW'($urandom_range(0, 3)), 1'($urandom), rnd_amt(),
                    rnd_amt());
          else it = mk(OP_EVAL, MW'($urandom), 1'($urandom), rnd_amt(), rnd_amt());
          send_beat(it, 0, 0, 0);
          sent++; s++;
          if (burst == 0) begin
            burst = $urandom_range(1, 8);
            if ($urandom_range(0, 2) == 0) go_idle($urandom_range(1, 5));
          end
          burst--;
        end
      end
    end

    start <= 1'b0;
    while (verdict_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (errors == 0) begin
      $display("best_fit_disk_request_check_unit_tb passed");
    end else begin
      $display("best_fit_disk_request_check_unit_tb failed");
    end
    $finish;
  end
endmodule
